// ===== hw/rtl/pru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

    localparam int ELEM_W  = 5;
    localparam int RANK_W  = 62;
    localparam int TDATA_W = 72;   // ELEM_W + RANK_W rounded up to whole bytes
    localparam int FACT_N  = 21;

    // n! for n = 0..20; out-of-range indexes read zero
    function automatic logic [RANK_W-1:0] fact_rom(input logic [ELEM_W-1:0] idx);
        logic [RANK_W-1:0] f;
        unique case (idx)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/permutation_rank_unrank.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Lehmer-code permutation ranker/unranker over 1..N (N = item_count, clamped to
// 1..MAX_ITEMS). Input tuser selects the operation: 0 feeds the next element of
// a permutation to rank, 1 feeds a 1-based rank to unrank. Ranking gives one
// result (tlast high) after the N-th element; unranking gives N element
// results, the last one with tlast. tuser on the output flags a bad input.
// The rank and factorial arithmetic runs on one shared 63-bit add/subtract
// unit under a small sequencer, and used-value masks are scanned one bit per
// cycle. A rank element counts the unused values below it, then adds the
// factorial once per count. An unrank checks and decrements the rank, then
// for each of its N digits finds the digit by repeated subtraction and scans
// the mask for the unused value that the digit selects. The
// block is ready for a new input only between items; a finished result may
// still be waiting in the output register when the next input is taken.

module permutation_rank_unrank #(
    parameter int MAX_ITEMS = 20
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration: item_count
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [pru_pkg::ELEM_W-1:0]   cfg_data,
    // input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [pru_pkg::TDATA_W-1:0]  s_tdata,  // element_in[4:0], rank_in[66:5], zero pad
    input  wire                          s_tuser,  // action
    // output stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [pru_pkg::TDATA_W-1:0]  m_tdata,  // element_out[4:0], rank_out[66:5], zero pad
    output logic                         m_tlast,  // is_last
    output logic                         m_tuser   // bad_input
);
    import pru_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_R_COUNT = 4'd1;
    localparam logic [3:0] ST_R_MAC   = 4'd2;
    localparam logic [3:0] ST_R_END   = 4'd3;
    localparam logic [3:0] ST_U_CHECK = 4'd4;
    localparam logic [3:0] ST_U_DEC   = 4'd5;
    localparam logic [3:0] ST_U_DIV   = 4'd6;
    localparam logic [3:0] ST_U_PICK  = 4'd7;
    localparam logic [3:0] ST_U_EMIT  = 4'd8;
    localparam logic [3:0] ST_U_BAD   = 4'd9;

    localparam logic [ELEM_W-1:0] MAX_N = ELEM_W'(MAX_ITEMS);
    localparam logic [ELEM_W-1:0] ONE5  = ELEM_W'(1);

    logic [3:0]           state_reg, state_next;
    logic [ELEM_W-1:0]    item_count_reg, item_count_next;
    logic [MAX_ITEMS-1:0] used_reg, used_next;
    logic [ELEM_W-1:0]    position_reg, position_next;
    logic [RANK_W-1:0]    acc_reg, acc_next;
    logic                 error_reg, error_next;
    logic [MAX_ITEMS-1:0] scratch_reg, scratch_next;
    logic [RANK_W-1:0]    p_reg, p_next;
    logic [ELEM_W-1:0]    e_reg, e_next;
    logic [ELEM_W-1:0]    idx_reg, idx_next;
    logic [ELEM_W-1:0]    cnt_reg, cnt_next;
    logic [ELEM_W-1:0]    dig_reg, dig_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ELEM_W-1:0]    elem_out_reg, elem_out_next;
    logic [RANK_W-1:0]    rank_out_reg, rank_out_next;
    logic                 last_reg, last_next;
    logic                 bad_reg, bad_next;

    logic [ELEM_W-1:0]    n_eff;
    logic [ELEM_W-1:0]    in_elem;
    logic [IDX_W-1:0]     in_bit;
    logic [IDX_W-1:0]     e_bit;
    logic [IDX_W-1:0]     scan_bit;
    logic                 out_free;

    // shared add/subtract unit
    logic                 alu_sub;
    logic [RANK_W-1:0]    alu_a, alu_b;
    logic [RANK_W:0]      alu_res;
    logic [ELEM_W-1:0]    fact_idx;
    logic [RANK_W-1:0]    fact_val;

    assign n_eff = (item_count_reg == '0) ? ONE5 :
                   ((item_count_reg > MAX_N) ? MAX_N : item_count_reg);

    assign in_elem  = s_tdata[ELEM_W-1:0];
    assign in_bit   = IDX_W'(in_elem - ONE5);
    assign e_bit    = IDX_W'(e_reg - ONE5);
    assign scan_bit = idx_reg[IDX_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    assign fact_val = fact_rom(fact_idx);
    // carry out of a subtract is high when a >= b
    assign alu_res  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (RANK_W+1)'(alu_sub);

    // a configuration write wins over an input offered in the same cycle
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(TDATA_W-RANK_W-ELEM_W){1'b0}}, rank_out_reg, elem_out_reg};
    assign m_tlast   = last_reg;
    assign m_tuser   = bad_reg;

    always_comb
    begin
        fact_idx = '0;
        alu_sub  = 1'b0;
        alu_a    = acc_reg;
        alu_b    = '0;
        unique case (state_reg)
            ST_R_MAC:
            begin
                fact_idx = n_eff - ONE5 - position_reg;
                alu_b    = fact_val;
            end
            ST_R_END:
            begin
                alu_b = RANK_W'(1);
            end
            ST_U_CHECK:
            begin
                fact_idx = n_eff;
                alu_sub  = 1'b1;
                alu_a    = fact_val;
                alu_b    = p_reg;
            end
            ST_U_DEC:
            begin
                alu_sub = 1'b1;
                alu_a   = p_reg;
                alu_b   = RANK_W'(1);
            end
            ST_U_DIV:
            begin
                fact_idx = idx_reg;
                alu_sub  = 1'b1;
                alu_a    = p_reg;
                alu_b    = fact_val;
            end
            default:
            begin
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        item_count_next = item_count_reg;
        used_next       = used_reg;
        position_next   = position_reg;
        acc_next        = acc_reg;
        error_next      = error_reg;
        scratch_next    = scratch_reg;
        p_next          = p_reg;
        e_next          = e_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        dig_next        = dig_reg;
        elem_out_next   = elem_out_reg;
        rank_out_next   = rank_out_reg;
        last_next       = last_reg;
        bad_next        = bad_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    item_count_next = cfg_data;
                    used_next       = '0;
                    position_next   = '0;
                    acc_next        = '0;
                    error_next      = 1'b0;
                end
                else if (s_tvalid)
                begin
                    if (!s_tuser)
                    begin
                        e_next   = in_elem;
                        idx_next = '0;
                        cnt_next = '0;
                        if (in_elem == '0 || in_elem > n_eff || used_reg[in_bit])
                        begin
                            error_next    = 1'b1;
                            position_next = position_reg + ONE5;
                            state_next    = ST_R_END;
                        end
                        else
                        begin
                            state_next = ST_R_COUNT;
                        end
                    end
                    else
                    begin
                        p_next     = s_tdata[RANK_W+ELEM_W-1:ELEM_W];
                        state_next = ST_U_CHECK;
                    end
                end
            end
            ST_R_COUNT:
            begin
                // count unused values below the element, one bit per cycle
                if (idx_reg == e_reg - ONE5)
                begin
                    state_next = ST_R_MAC;
                end
                else
                begin
                    if (!used_reg[scan_bit])
                    begin
                        cnt_next = cnt_reg + ONE5;
                    end
                    idx_next = idx_reg + ONE5;
                end
            end
            ST_R_MAC:
            begin
                // count * factorial by repeated addition
                if (cnt_reg == '0)
                begin
                    used_next[e_bit] = 1'b1;
                    position_next    = position_reg + ONE5;
                    state_next       = ST_R_END;
                end
                else
                begin
                    acc_next = alu_res[RANK_W-1:0];
                    cnt_next = cnt_reg - ONE5;
                end
            end
            ST_R_END:
            begin
                if (position_reg < n_eff)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    elem_out_next = '0;
                    rank_out_next = error_reg ? '0 : alu_res[RANK_W-1:0];
                    last_next     = 1'b1;
                    bad_next      = error_reg;
                    used_next     = '0;
                    position_next = '0;
                    acc_next      = '0;
                    error_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            ST_U_CHECK:
            begin
                if (p_reg == '0 || !alu_res[RANK_W])
                begin
                    state_next = ST_U_BAD;
                end
                else
                begin
                    state_next = ST_U_DEC;
                end
            end
            ST_U_DEC:
            begin
                p_next       = alu_res[RANK_W-1:0];
                scratch_next = '0;
                idx_next     = n_eff - ONE5;   // digit position i
                dig_next     = '0;
                state_next   = ST_U_DIV;
            end
            ST_U_DIV:
            begin
                // digit = p / i! by repeated subtraction, p keeps the remainder
                if (alu_res[RANK_W])
                begin
                    p_next   = alu_res[RANK_W-1:0];
                    dig_next = dig_reg + ONE5;
                end
                else
                begin
                    e_next     = idx_reg;      // park i while scanning
                    idx_next   = '0;
                    state_next = ST_U_PICK;
                end
            end
            ST_U_PICK:
            begin
                // find the dig-th unused value
                if (scratch_reg[scan_bit])
                begin
                    idx_next = idx_reg + ONE5;
                end
                else if (dig_reg == '0)
                begin
                    scratch_next[scan_bit] = 1'b1;
                    state_next             = ST_U_EMIT;
                end
                else
                begin
                    dig_next = dig_reg - ONE5;
                    idx_next = idx_reg + ONE5;
                end
            end
            ST_U_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    elem_out_next = idx_reg + ONE5;
                    rank_out_next = '0;
                    last_next     = (e_reg == '0);
                    bad_next      = 1'b0;
                    if (e_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = e_reg - ONE5;
                        dig_next   = '0;
                        state_next = ST_U_DIV;
                    end
                end
            end
            ST_U_BAD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    elem_out_next = '0;
                    rank_out_next = '0;
                    last_next     = 1'b1;
                    bad_next      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_count_reg <= ELEM_W'(20);
            used_reg       <= '0;
            position_reg   <= '0;
            acc_reg        <= '0;
            error_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            item_count_reg <= item_count_next;
            used_reg       <= used_next;
            position_reg   <= position_next;
            acc_reg        <= acc_next;
            error_reg      <= error_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scratch_reg  <= scratch_next;
        p_reg        <= p_next;
        e_reg        <= e_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        dig_reg      <= dig_next;
        elem_out_reg <= elem_out_next;
        rank_out_reg <= rank_out_next;
        last_reg     <= last_next;
        bad_reg      <= bad_next;
    end

endmodule

`default_nettype wire

// ===== test/permutation_rank_unrank_checker.sv =====
`timescale 1ns / 1ps

module permutation_rank_unrank_checker
    import pru_pkg::*;
#(
    parameter int MAX_ITEMS = 20
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_valid,
    input  wire                  cfg_ready,
    input  wire  [ELEM_W-1:0]    cfg_data,
    input  wire                  s_tvalid,
    input  wire                  s_tready,
    input  wire  [TDATA_W-1:0]   s_tdata,  // element_in[4:0], rank_in[66:5], zero pad
    input  wire                  s_tuser,  // action
    input  wire                  m_tvalid,
    input  wire                  m_tready,
    input  wire  [TDATA_W-1:0]   m_tdata,  // element_out[4:0], rank_out[66:5], zero pad
    input  wire                  m_tlast,  // is_last
    input  wire                  m_tuser,  // bad_input
    output int                   pending,
    output int                   fail_count
);

    localparam bit ACT_UNRANK = 1'b1;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [RANK_W-1:0] rank;
        logic              last;
        logic              bad;
    } perm_result_t;

    perm_result_t      expected_results[$];
    logic [ELEM_W-1:0] length_reg;
    logic [31:0]       used_mask;
    int unsigned       position;
    logic [RANK_W-1:0] rank_acc;
    logic              error_seen;
    int                mismatches;

    function automatic longint unsigned factorial(input int unsigned k);
        longint unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= k; i++)
            f = f * i;
        return f;
    endfunction

    // register value 0 behaves as 1, anything past MAX_ITEMS as MAX_ITEMS
    function automatic int unsigned active_length();
        if (length_reg < 1)
            return 1;
        if (length_reg > MAX_ITEMS)
            return MAX_ITEMS;
        return 32'(length_reg);
    endfunction

    task automatic clear_ranking();
        used_mask  = '0;
        position   = 0;
        rank_acc   = '0;
        error_seen = 1'b0;
    endtask

    task automatic take_element(input logic [ELEM_W-1:0] e);
        int unsigned     n;
        logic [31:0]     full;
        logic [31:0]     sel_bit;
        int unsigned     below;
        longint unsigned sum;
        perm_result_t    res;
        n    = active_length();
        full = (32'd1 << n) - 32'd1;
        if (e < 1 || e > n) begin
            error_seen = 1'b1;
        end
        else begin
            sel_bit = 32'd1 << (e - 1);
            if ((used_mask & sel_bit) != 0) begin
                error_seen = 1'b1;
            end
            else begin
                below     = $countones(~used_mask & full & (sel_bit - 32'd1));
                sum       = rank_acc + factorial(n - 1 - position) * below;
                rank_acc  = sum[RANK_W-1:0];
                used_mask = used_mask | sel_bit;
            end
        end
        // a bad element still uses up a position
        position++;
        if (position >= n) begin
            res.element = '0;
            res.rank    = error_seen ? '0 : rank_acc + 1'b1;
            res.last    = 1'b1;
            res.bad     = error_seen;
            expected_results.push_back(res);
            clear_ranking();
        end
    endtask

    // works on its own mask; a ranking in progress is left alone
    task automatic unrank_value(input logic [RANK_W-1:0] r);
        int unsigned       n;
        longint unsigned   p;
        longint unsigned   f;
        longint unsigned   d;
        logic [31:0]       scratch;
        logic [ELEM_W-1:0] pick;
        perm_result_t      res;
        n = active_length();
        if (r == 0 || r > factorial(n)) begin
            res.element = '0;
            res.rank    = '0;
            res.last    = 1'b1;
            res.bad     = 1'b1;
            expected_results.push_back(res);
        end
        else begin
            p       = r - 1;
            scratch = '0;
            for (int i = n - 1; i >= 0; i--) begin
                f    = factorial(i);
                d    = p / f;
                pick = '0;
                for (int j = 0; j < n; j++) begin
                    if (!scratch[j] && pick == 0) begin
                        if (d == 0) begin
                            pick       = ELEM_W'(j + 1);
                            scratch[j] = 1'b1;
                        end
                        else begin
                            d--;
                        end
                    end
                end
                p           = p % f;
                res.element = pick;
                res.rank    = '0;
                res.last    = (i == 0);
                res.bad     = 1'b0;
                expected_results.push_back(res);
            end
        end
    endtask

    task automatic compare_result();
        perm_result_t      want;
        logic [ELEM_W-1:0] got_element;
        logic [RANK_W-1:0] got_rank;
        got_element = m_tdata[ELEM_W-1:0];
        got_rank    = m_tdata[ELEM_W +: RANK_W];
        if (expected_results.size() == 0) begin
            $error("unexpected output transfer: element_out %0d rank_out %0d is_last %0b",
                   got_element, got_rank, m_tlast);
            mismatches++;
        end
        else begin
            want = expected_results.pop_front();
            if (got_element !== want.element) begin
                $error("element_out: expected %0d, actual %0d", want.element, got_element);
                mismatches++;
            end
            if (got_rank !== want.rank) begin
                $error("rank_out: expected %0d, actual %0d", want.rank, got_rank);
                mismatches++;
            end
            if (m_tlast !== want.last) begin
                $error("is_last: expected %0b, actual %0b", want.last, m_tlast);
                mismatches++;
            end
            if (m_tuser !== want.bad) begin
                $error("bad_input: expected %0b, actual %0b", want.bad, m_tuser);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_results.delete();
            length_reg = 5'd20;
            clear_ranking();
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else begin
            if (m_tvalid && m_tready)
                compare_result();
            if (cfg_valid && cfg_ready) begin
                length_reg = cfg_data;
                clear_ranking();
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == ACT_UNRANK)
                    unrank_value(s_tdata[ELEM_W +: RANK_W]);
                else
                    take_element(s_tdata[ELEM_W-1:0]);
            end
            pending    <= expected_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== test/tb_permutation_rank_unrank.sv =====
`timescale 1ns / 1ps

module tb_permutation_rank_unrank;
    import pru_pkg::*;

    localparam int MAX_ITEMS     = 20;
    localparam bit ACT_RANK      = 1'b0;
    localparam bit ACT_UNRANK    = 1'b1;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 200;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [ELEM_W-1:0]  cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // element_in[4:0], rank_in[66:5], zero pad
    logic               s_tuser;   // action
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;   // element_out[4:0], rank_out[66:5], zero pad
    logic               m_tlast;   // is_last
    logic               m_tuser;   // bad_input

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int quiet_cycles;
    int pending;
    int fail_count;

    permutation_rank_unrank #(
        .MAX_ITEMS (MAX_ITEMS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    permutation_rank_unrank_checker #(
        .MAX_ITEMS (MAX_ITEMS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [RANK_W-1:0] random_rank_bits();
        logic [63:0] x;
        x = {$urandom, $urandom};
        return x[RANK_W-1:0];
    endfunction

    function automatic logic [RANK_W-1:0] legal_rank(input int n);
        longint unsigned x;
        x = {$urandom, $urandom};
        return RANK_W'(x % fact_rom(n[ELEM_W-1:0]) + 1);
    endfunction

    // tvalid stays high across back-to-back transfers; lowered only on a gap
    task automatic send_item(input bit act, input logic [ELEM_W-1:0] e,
                             input logic [RANK_W-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(TDATA_W - ELEM_W - RANK_W){1'b0}}, r, e};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_element(input logic [ELEM_W-1:0] e);
        send_item(ACT_RANK, e, random_rank_bits());
    endtask

    task automatic send_rank(input logic [RANK_W-1:0] r);
        send_item(ACT_UNRANK, ELEM_W'($urandom_range(0, 31)), r);
    endtask

    task automatic write_length(input logic [ELEM_W-1:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // a trailing rank element gives no result but may still be in work
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // shuffled permutation, now and then with one bad element or an unrank mixed in
    task automatic rank_permutation(input int n);
        int perm[MAX_ITEMS];
        int j;
        int tmp;
        int bad_at;
        int mix_at;
        for (int i = 0; i < n; i++)
            perm[i] = i + 1;
        for (int i = n - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        bad_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n - 1) : -1;
        mix_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == mix_at)
                send_rank(legal_rank(n));
            if (i != bad_at)
                send_element(ELEM_W'(perm[i]));
            else if ($urandom_range(0, 1) == 1)
                send_element(ELEM_W'($urandom_range(0, 31)));
            else
                send_element(ELEM_W'(perm[0]));
        end
    endtask

    initial begin
        int          lengths[12];
        int          n;
        int          stop_at;
        int          sel;
        logic [RANK_W-1:0] top_rank;

        lengths       = '{3, 1, 20, 0, 5, 31, 2, 7, 4, 21, 6, 12};
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = ACT_RANK;
        send_idle_pct = 8;
        recv_idle_pct = 70;
        items_sent    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // length 20 out of reset: rank extremes and out-of-range ranks
        send_rank(fact_rom(5'd20));
        send_rank(62'd1);
        send_rank(fact_rom(5'd20) + 1);
        send_rank(62'd0);
        send_rank({RANK_W{1'b1}});

        write_length(5'd4);
        send_element(5'd4);
        send_element(5'd3);
        send_element(5'd2);
        send_element(5'd1);
        // zero, too large and repeated elements, unrank in the middle
        send_element(5'd2);
        send_rank(62'd5);
        send_element(5'd0);
        send_element(5'd31);
        send_element(5'd2);
        // a register write drops the partial ranking
        send_element(5'd2);
        send_element(5'd3);
        write_length(5'd4);
        send_element(5'd1);
        send_element(5'd2);
        send_element(5'd3);
        send_element(5'd4);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 8;  recv_idle_pct = 70; end
                1: begin send_idle_pct = 70; recv_idle_pct = 8;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 4; k++) begin
                write_length(ELEM_W'(lengths[ph * 4 + k]));
                n = lengths[ph * 4 + k];
                if (n < 1)
                    n = 1;
                else if (n > MAX_ITEMS)
                    n = MAX_ITEMS;
                top_rank = fact_rom(n[ELEM_W-1:0]);
                stop_at  = items_sent + ((n >= 13) ? 26 : 36);
                while (items_sent < stop_at) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 55)
                        rank_permutation(n);
                    else if (sel < 80)
                        send_rank(legal_rank(n));
                    else if (sel < 85)
                        send_rank(($urandom_range(0, 1) == 1) ? top_rank : 62'd1);
                    else if (sel < 90)
                        send_element(ELEM_W'($urandom_range(0, 31)));
                    else if (sel < 94)
                        send_rank(random_rank_bits());
                    else if (sel < 97)
                        send_rank(top_rank + 1);
                    else
                        send_rank(62'd0);
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
